// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/amb_pkg.sv =====
// ----------------------------------------------------------------------------
// amb_pkg
// Types and constants for the audio multi-buffer ring.
// ----------------------------------------------------------------------------
`default_nettype none

package amb_pkg;

    localparam int AMB_MAX_SLOTS = 16;
    localparam int AMB_MAX_PAIRS = 512;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [4:0] BUFFER_COUNT_RST       = 5'd3;
    localparam logic [9:0] SAMPLES_PER_BUFFER_RST = 10'd512;
    localparam logic       LIMIT_MODE_RST         = 1'b0;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_CLAIM = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_BUFFER_COUNT       = 2'd0,
        REG_SAMPLES_PER_BUFFER = 2'd1,
        REG_LIMIT_MODE         = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== rtl/amb_if.sv =====
// ----------------------------------------------------------------------------
// amb_if
// Request and response channels (valid/ready) of the audio multi-buffer ring.
// ----------------------------------------------------------------------------
`default_nettype none

interface amb_req_if;
    import amb_pkg::*;

    logic        valid;
    logic        ready;
    t_func       func;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic [3:0]  slot_sel;
    logic [8:0]  pair_offset;

    modport source (
        output valid, func, left_in, right_in, slot_sel, pair_offset,
        input  ready
    );
    modport sink (
        input  valid, func, left_in, right_in, slot_sel, pair_offset,
        output ready
    );
endinterface

interface amb_rsp_if;
    import amb_pkg::*;

    logic        valid;
    logic        ready;
    t_status     status;
    logic [3:0]  slot_out;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (
        output valid, status, slot_out, left_out, right_out,
        input  ready
    );
    modport sink (
        input  valid, status, slot_out, left_out, right_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/audio_multi_buffer_ring.sv =====
// ----------------------------------------------------------------------------
// audio_multi_buffer_ring
// Ring of fixed-size stereo buffers between a sample producer and a player.
//
// i_req carries one transaction per item: write a pair into the current
// buffer, claim the oldest filled buffer, or read a stored pair back.
// o_rsp returns exactly one transaction per item, in order: status, the
// claimed slot and the pair read back. The APB port holds buffer_count,
// samples_per_buffer and limit_mode; write them only while idle.
// A result passes the read stage, then the output register. Throughput:
// one item per cycle unless o_rsp stalls or the clearing pass runs, set by
// the single port of the sample memory (reads and writes share it, never in
// the same cycle). Reset: control clears, registers load reset values, then
// a clearing pass zeroes all MAX_SLOTS*MAX_PAIRS memory entries (8192 by
// default), one a cycle; i_req.ready stays low until it ends. APB stays live.
// Stall: a result waits in the output register; one more item sits in the
// read stage behind it, then i_req.ready drops until o_rsp is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module audio_multi_buffer_ring #(
    parameter int MAX_SLOTS = amb_pkg::AMB_MAX_SLOTS,
    parameter int MAX_PAIRS = amb_pkg::AMB_MAX_PAIRS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    amb_req_if.sink                               i_req,
    amb_rsp_if.source                             o_rsp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [amb_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [amb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [amb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import amb_pkg::*;

    localparam int DEPTH  = MAX_SLOTS * MAX_PAIRS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int OFF_W  = $clog2(MAX_PAIRS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0] r_buffer_count;
    logic [9:0] r_samples_per_buffer;
    logic       r_limit_mode;
    logic       cfg_we;
    t_reg_idx   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_count       <= BUFFER_COUNT_RST;
            r_samples_per_buffer <= SAMPLES_PER_BUFFER_RST;
            r_limit_mode         <= LIMIT_MODE_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_BUFFER_COUNT:       r_buffer_count       <= pwdata[4:0];
                REG_SAMPLES_PER_BUFFER: r_samples_per_buffer <= pwdata[9:0];
                REG_LIMIT_MODE:         r_limit_mode         <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BUFFER_COUNT:       prdata = APB_DATA_W'(r_buffer_count);
            REG_SAMPLES_PER_BUFFER: prdata = APB_DATA_W'(r_samples_per_buffer);
            REG_LIMIT_MODE:         prdata = APB_DATA_W'(r_limit_mode);
            default:                prdata = '0;
        endcase
    end

    // Effective (clamped) ring size and buffer length
    logic [CNT_W-1:0] eff_count;
    logic [OFF_W-1:0] eff_pairs;

    always_comb begin
        if (r_buffer_count < 5'd2) begin
            eff_count = CNT_W'(2);
        end else if (int'(r_buffer_count) > MAX_SLOTS) begin
            eff_count = CNT_W'(MAX_SLOTS);
        end else begin
            eff_count = CNT_W'(r_buffer_count);
        end

        if (r_samples_per_buffer == 10'd0) begin
            eff_pairs = OFF_W'(1);
        end else if (int'(r_samples_per_buffer) > MAX_PAIRS) begin
            eff_pairs = OFF_W'(MAX_PAIRS);
        end else begin
            eff_pairs = OFF_W'(r_samples_per_buffer);
        end
    end

    function automatic logic [SLOT_W-1:0] f_next_slot(
        input logic [SLOT_W-1:0] s,
        input logic [CNT_W-1:0]  cnt
    );
        logic [CNT_W:0] n;
        n = (CNT_W+1)'(s) + 1'b1;
        return (n >= {1'b0, cnt}) ? '0 : SLOT_W'(n);
    endfunction

    // ------------------------------------------------------------------
    // Ring control state
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] r_wslot, n_wslot;
    logic [SLOT_W-1:0] r_rslot, n_rslot;
    logic [CNT_W-1:0]  r_filled, n_filled;
    logic [OFF_W-1:0]  r_woff, n_woff;
    logic              r_pending, n_pending;

    // Clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Pipeline: read stage then output register
    logic              r_s1_valid;
    t_status           r_s1_status;
    logic [3:0]        r_s1_slot;
    logic              r_s1_rd;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [3:0]        r_out_slot;
    logic [31:0]       r_out_pair;

    logic              s1_move;
    logic              in_ready;
    logic              in_acc;
    t_status           acc_status;
    logic [3:0]        acc_slot;
    logic              acc_rd;

    // Memory port
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic [31:0]       r_rdata;
    logic [31:0]       r_sample_store [DEPTH];

    // Scratch for the update
    logic [OFF_W:0]    woff_inc;
    logic [CNT_W-1:0]  filled_mid;
    logic              wr_hit;
    logic              rd_in_range;

    assign s1_move     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready    = !r_clr_busy && (!r_s1_valid || s1_move);
    assign in_acc      = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    assign rd_in_range = (int'(i_req.slot_sel) < MAX_SLOTS)
                      && (int'(i_req.pair_offset) < MAX_PAIRS);

    always_comb begin
        n_wslot    = r_wslot;
        n_rslot    = r_rslot;
        n_filled   = r_filled;
        n_woff     = r_woff;
        n_pending  = r_pending;
        acc_status = ST_OK;
        acc_slot   = 4'd0;
        acc_rd     = 1'b0;
        wr_hit     = 1'b0;
        woff_inc   = (OFF_W+1)'(r_woff) + 1'b1;
        filled_mid = r_filled;

        if (in_acc) begin
            case (i_req.func)
                FUNC_WRITE: begin
                    if (r_pending) begin
                        acc_status = ST_BLOCKED;
                    end else begin
                        wr_hit = (int'(r_woff) < MAX_PAIRS);
                        if (woff_inc >= {1'b0, eff_pairs}) begin
                            acc_status = ST_DONE;
                            if (({1'b0, r_filled} + 1'b1) < {1'b0, eff_count}) begin
                                n_filled = r_filled + 1'b1;
                                n_wslot  = f_next_slot(r_wslot, eff_count);
                                n_woff   = '0;
                            end else if (!r_limit_mode) begin
                                n_woff = '0;
                            end else begin
                                n_woff    = OFF_W'(woff_inc);
                                n_pending = 1'b1;
                            end
                        end else begin
                            n_woff = OFF_W'(woff_inc);
                        end
                    end
                end
                FUNC_CLAIM: begin
                    if (r_filled == '0) begin
                        acc_status = ST_EMPTY;
                    end else begin
                        acc_slot   = 4'(r_rslot);
                        n_rslot    = f_next_slot(r_rslot, eff_count);
                        filled_mid = r_filled - 1'b1;
                    end
                    n_filled = filled_mid;
                    // a freed buffer lets a deferred move go ahead
                    if (r_pending && (({1'b0, filled_mid} + 1'b1) < {1'b0, eff_count})) begin
                        n_filled  = filled_mid + 1'b1;
                        n_wslot   = f_next_slot(r_wslot, eff_count);
                        n_woff    = '0;
                        n_pending = 1'b0;
                    end
                end
                FUNC_READ: begin
                    acc_rd = rd_in_range;
                end
                default: ;
            endcase
        end
    end

    // Single memory port: clearing pass, sample write or sample read
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = {i_req.right_in, i_req.left_in};
        mem_addr  = ADDR_W'(int'(r_wslot) * MAX_PAIRS + int'(r_woff));
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            mem_addr  = r_clr_addr;
        end else if (wr_hit) begin
            mem_we = 1'b1;
        end else if (acc_rd) begin
            mem_re   = 1'b1;
            mem_addr = ADDR_W'(int'(i_req.slot_sel) * MAX_PAIRS
                             + int'(i_req.pair_offset));
        end
    end

    // Read data is held while the read stage stalls (no new access then)
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sample_store[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_sample_store[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot    <= '0;
            r_rslot    <= '0;
            r_filled   <= '0;
            r_woff     <= '0;
            r_pending  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_wslot   <= n_wslot;
            r_rslot   <= n_rslot;
            r_filled  <= n_filled;
            r_woff    <= n_woff;
            r_pending <= n_pending;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // Read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= acc_status;
            r_s1_slot   <= acc_slot;
            r_s1_rd     <= acc_rd;
        end
        if (s1_move) begin
            r_out_status <= r_s1_status;
            r_out_slot   <= r_s1_slot;
            r_out_pair   <= r_s1_rd ? r_rdata : 32'd0;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.slot_out  = r_out_slot;
    assign o_rsp.left_out  = r_out_pair[15:0];
    assign o_rsp.right_out = r_out_pair[31:16];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_no_accept_in_clear, i_clk, i_rst_n, r_clr_busy, !in_acc)
    `ASSERT_NEXT(a_blocked_write, i_clk, i_rst_n,
        in_acc && (i_req.func == FUNC_WRITE) && r_pending,
        r_s1_status == ST_BLOCKED)
    `ASSERT_NEXT(a_rdata_held, i_clk, i_rst_n,
        r_s1_valid && !s1_move, $stable(r_rdata))

endmodule

`default_nettype wire
